FILE: rtl/core/kmeans_2d_clustering_defines.svh
// Assertion macros shared by the RTL.
`ifndef KMEANS_2D_CLUSTERING_DEFINES_SVH
`define KMEANS_2D_CLUSTERING_DEFINES_SVH

// Same-cycle implication.
`define KM2D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KM2D_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/km2d_pkg.sv
package km2d_pkg;

   localparam int DEF_MAX_POINTS  = 1024;
   localparam int DEF_MAX_CLASSES = 16;
   localparam int DEF_COORD_BITS  = 16;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 10;
   localparam int FIELD_W = 16;
   localparam int LABEL_W = 4;
   localparam int ITER_W  = 16;
   localparam int KREG_W  = 5;
   localparam int NREG_W  = 11;
   localparam int CSR_W   = 2;

   localparam logic [OP_W-1:0] OP_WR_CEN = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_PT  = 3'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_CEN = 3'd3;
   localparam logic [OP_W-1:0] OP_RD_LBL = 3'd4;

   localparam logic [CSR_W-1:0] CSR_ITER  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_CLASS = 2'd1;
   localparam logic [CSR_W-1:0] CSR_POINT = 2'd2;

   // Tag that travels with a centroid read into the distance unit.
   typedef struct packed {
      logic valid;
      logic first;
   } km2d_tag_type;

endpackage

FILE: rtl/core/km2d_ram.sv
module km2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/km2d_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module km2d_div #(
   parameter int NW = 26,
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int CNTW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [DW:0]     trial;
   logic [DW:0]     shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/core/km2d_dist.sv
// Squared distance of one point to a stream of centroids; keeps the nearest.
module km2d_dist #(
   parameter int CB = 16,
   parameter int CW = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  km2d_pkg::km2d_tag_type tag,
   input  logic [CW-1:0]         cls,
   input  logic signed [CB-1:0]  px,
   input  logic signed [CB-1:0]  py,
   input  logic signed [CB-1:0]  cx,
   input  logic signed [CB-1:0]  cy,
   output logic                  busy,
   output logic [CW-1:0]         best
);

   logic signed [CB:0]   dx, dy;
   logic [2*CB:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [2*CB+1:0]      dist_sum;
   logic [2*CB+1:0]      best_d_ff;
   logic [CW-1:0]        best_ff;
   logic [CW-1:0]        cls_ff;
   logic                 vld_ff, first_ff;

   assign dx       = {px[CB-1], px} - {cx[CB-1], cx};
   assign dy       = {py[CB-1], py} - {cy[CB-1], cy};
   assign sqx_in   = (2*CB+1)'(dx * dx);
   assign sqy_in   = (2*CB+1)'(dy * dy);
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= tag.valid;
      end
      first_ff <= tag.first;
      cls_ff   <= cls;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      // strict less: ties keep the lower class
      if (vld_ff && (first_ff || dist_sum < best_d_ff)) begin
         best_ff   <= cls_ff;
         best_d_ff <= dist_sum;
      end
   end

   assign busy = vld_ff;
   assign best = best_ff;

endmodule

FILE: rtl/core/kmeans_2d_clustering.sv
// Load and read requests: one per cycle while idle and the response side is not stalled;
// the response passes the front stage, then the response register, before it is valid.
// Run request: I iterations, each a per-point centroid RAM walk and per-class serial divides.
// Reset: synchronous; registers return to defaults, then a pass zeroes all MAX_POINTS label
// entries while no request is taken (csr writes still accepted).
`include "kmeans_2d_clustering_defines.svh"

module kmeans_2d_clustering #(
   parameter int MAX_POINTS  = km2d_pkg::DEF_MAX_POINTS,
   parameter int MAX_CLASSES = km2d_pkg::DEF_MAX_CLASSES,
   parameter int COORD_BITS  = km2d_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [km2d_pkg::OP_W-1:0]         req_operation,
   input  logic [km2d_pkg::IDX_W-1:0]        req_index,
   input  logic signed [km2d_pkg::FIELD_W-1:0] req_coord_x,
   input  logic signed [km2d_pkg::FIELD_W-1:0] req_coord_y,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [km2d_pkg::FIELD_W-1:0] rsp_read_x,
   output logic signed [km2d_pkg::FIELD_W-1:0] rsp_read_y,
   output logic [km2d_pkg::LABEL_W-1:0]      rsp_read_label,
   output logic                              rsp_done_res,
   // csr write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [km2d_pkg::CSR_W-1:0]        csr_index,
   input  logic [km2d_pkg::FIELD_W-1:0]      csr_data
);

   localparam int CB  = COORD_BITS;
   localparam int PW  = $clog2(MAX_POINTS);
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int CW  = $clog2(MAX_CLASSES);
   localparam int CCW = $clog2(MAX_CLASSES + 1);
   localparam int SW  = CB + PCW - 1;          // per-class coordinate sum
   localparam int AW  = 2 * SW + PCW;          // sum RAM entry: {sx, sy, count}

   // sequencer states
   localparam logic [3:0] ST_CLR   = 4'd0;   // label clearing pass after reset
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_START = 4'd2;
   localparam logic [3:0] ST_SCLR  = 4'd3;   // zero the class sums
   localparam logic [3:0] ST_PRD   = 4'd4;   // fetch point
   localparam logic [3:0] ST_SCAN  = 4'd5;   // stream centroids into distance unit
   localparam logic [3:0] ST_DRAIN = 4'd6;
   localparam logic [3:0] ST_ARD   = 4'd7;   // read class sum
   localparam logic [3:0] ST_AWR   = 4'd8;   // accumulate, write label
   localparam logic [3:0] ST_URD   = 4'd9;   // update: read class sum
   localparam logic [3:0] ST_UCHK  = 4'd10;
   localparam logic [3:0] ST_UDIV  = 4'd11;
   localparam logic [3:0] ST_UWR   = 4'd12;
   localparam logic [3:0] ST_FIN   = 4'd13;

   // ---------------- csr registers ----------------
   logic [km2d_pkg::ITER_W-1:0] iter_ff;
   logic [km2d_pkg::KREG_W-1:0] kreg_ff;
   logic [km2d_pkg::NREG_W-1:0] nreg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= km2d_pkg::ITER_W'(1);
         kreg_ff <= km2d_pkg::KREG_W'(16);
         nreg_ff <= km2d_pkg::NREG_W'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            km2d_pkg::CSR_ITER:  iter_ff <= csr_data;
            km2d_pkg::CSR_CLASS: kreg_ff <= csr_data[km2d_pkg::KREG_W-1:0];
            km2d_pkg::CSR_POINT: nreg_ff <= csr_data[km2d_pkg::NREG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped class and point counts
   logic [CCW-1:0] k_eff;
   logic [PCW-1:0] n_eff;
   assign k_eff = (kreg_ff == '0) ? CCW'(1) :
                  (32'(kreg_ff) > MAX_CLASSES) ? CCW'(MAX_CLASSES) : CCW'(kreg_ff);
   assign n_eff = (32'(nreg_ff) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(nreg_ff);

   // ---------------- state ----------------
   logic [3:0]                  state_ff, state_in;
   logic [PCW-1:0]              p_ff, p_in;
   logic [CCW-1:0]              c_ff, c_in;
   logic [km2d_pkg::ITER_W-1:0] it_ff, it_in;
   logic                        tag_vld_ff, tag_vld_in, tag_first_ff, tag_first_in;
   logic [CW-1:0]               tag_cls_ff, tag_cls_in;
   logic                        sgn_x_ff, sgn_x_in, sgn_y_ff, sgn_y_in;

   // front-end stage and response register
   logic                        s1_vld_ff, s1_vld_in;
   logic [km2d_pkg::OP_W-1:0]   s1_op_ff, s1_op_in;
   logic                        s1_inr_ff, s1_inr_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic signed [km2d_pkg::FIELD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [km2d_pkg::LABEL_W-1:0] rsp_lbl_ff, rsp_lbl_in;
   logic                        rsp_done_ff, rsp_done_in;

   logic s1_adv, accept, last_c, last_p;

   // ---------------- memories ----------------
   logic                 pt_we, pt_re;
   logic [PW-1:0]        pt_waddr, pt_raddr;
   logic [2*CB-1:0]      pt_wdata, pt_rdata;
   logic                 cen_we, cen_re;
   logic [CW-1:0]        cen_waddr, cen_raddr;
   logic [2*CB-1:0]      cen_wdata, cen_rdata;
   logic                 lbl_we, lbl_re;
   logic [PW-1:0]        lbl_waddr, lbl_raddr;
   logic [CW-1:0]        lbl_wdata, lbl_rdata;
   logic                 sum_we, sum_re;
   logic [CW-1:0]        sum_waddr, sum_raddr;
   logic [AW-1:0]        sum_wdata, sum_rdata;

   km2d_ram #(.WIDTH(2*CB), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock, .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_en(pt_re), .rd_addr(pt_raddr), .rd_data(pt_rdata));
   km2d_ram #(.WIDTH(2*CB), .DEPTH(MAX_CLASSES)) u_cen_ram (
      .clock, .wr_en(cen_we), .wr_addr(cen_waddr), .wr_data(cen_wdata),
      .rd_en(cen_re), .rd_addr(cen_raddr), .rd_data(cen_rdata));
   km2d_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_lbl_ram (
      .clock, .wr_en(lbl_we), .wr_addr(lbl_waddr), .wr_data(lbl_wdata),
      .rd_en(lbl_re), .rd_addr(lbl_raddr), .rd_data(lbl_rdata));
   km2d_ram #(.WIDTH(AW), .DEPTH(MAX_CLASSES)) u_sum_ram (
      .clock, .wr_en(sum_we), .wr_addr(sum_waddr), .wr_data(sum_wdata),
      .rd_en(sum_re), .rd_addr(sum_raddr), .rd_data(sum_rdata));

   // point and centroid words: {x, y}
   logic signed [CB-1:0] pt_x, pt_y, cen_x, cen_y, in_x, in_y;
   assign pt_x  = pt_rdata[2*CB-1:CB];
   assign pt_y  = pt_rdata[CB-1:0];
   assign cen_x = cen_rdata[2*CB-1:CB];
   assign cen_y = cen_rdata[CB-1:0];
   // coordinates narrower than the field take the low bits
   assign in_x  = CB'($unsigned(req_coord_x));
   assign in_y  = CB'($unsigned(req_coord_y));

   // sum RAM fields
   logic signed [SW-1:0] sum_x, sum_y;
   logic [PCW-1:0]       sum_n;
   assign sum_x = sum_rdata[AW-1:SW+PCW];
   assign sum_y = sum_rdata[SW+PCW-1:PCW];
   assign sum_n = sum_rdata[PCW-1:0];

   // ---------------- distance unit ----------------
   km2d_pkg::km2d_tag_type tag;
   logic                   dist_busy;
   logic [CW-1:0]          best;

   assign tag = '{valid: tag_vld_ff, first: tag_first_ff};

   km2d_dist #(.CB(CB), .CW(CW)) u_dist (
      .clock, .reset, .tag, .cls(tag_cls_ff), .px(pt_x), .py(pt_y),
      .cx(cen_x), .cy(cen_y), .busy(dist_busy), .best(best));

   // ---------------- dividers (mean) ----------------
   logic                 div_start, div_busy_x, div_busy_y;
   logic [SW-1:0]        mag_x, mag_y, quo_x, quo_y;
   logic [CB-1:0]        q_x, q_y;

   assign mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
   assign mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);

   km2d_div #(.NW(SW), .DW(PCW)) u_div_x (
      .clock, .reset, .start(div_start), .num(mag_x), .den(sum_n),
      .busy(div_busy_x), .quo(quo_x));
   km2d_div #(.NW(SW), .DW(PCW)) u_div_y (
      .clock, .reset, .start(div_start), .num(mag_y), .den(sum_n),
      .busy(div_busy_y), .quo(quo_y));

   // mean magnitude fits CB bits; negate for truncation toward zero
   assign q_x = sgn_x_ff ? CB'(-quo_x[CB-1:0]) : quo_x[CB-1:0];
   assign q_y = sgn_y_ff ? CB'(-quo_y[CB-1:0]) : quo_y[CB-1:0];

   // ---------------- control ----------------
   assign s1_adv    = !rsp_vld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!s1_vld_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign last_c    = (c_ff + 1'b1) == k_eff;
   assign last_p    = (p_ff + 1'b1) == n_eff;

   logic [SW-1:0]  acc_x, acc_y;
   logic [PCW-1:0] acc_n;
   assign acc_x = sum_x + SW'(pt_x);
   assign acc_y = sum_y + SW'(pt_y);
   assign acc_n = sum_n + 1'b1;

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      c_in         = c_ff;
      it_in        = it_ff;
      tag_vld_in   = 1'b0;
      tag_first_in = tag_first_ff;
      tag_cls_in   = tag_cls_ff;
      sgn_x_in     = sgn_x_ff;
      sgn_y_in     = sgn_y_ff;

      pt_we     = 1'b0;
      pt_waddr  = PW'(req_index);
      pt_wdata  = {in_x, in_y};
      pt_re     = 1'b0;
      pt_raddr  = p_ff[PW-1:0];
      cen_we    = 1'b0;
      cen_waddr = CW'(req_index);
      cen_wdata = {in_x, in_y};
      cen_re    = 1'b0;
      cen_raddr = CW'(req_index);
      lbl_we    = 1'b0;
      lbl_waddr = p_ff[PW-1:0];
      lbl_wdata = best;
      lbl_re    = 1'b0;
      lbl_raddr = PW'(req_index);
      sum_we    = 1'b0;
      sum_waddr = c_ff[CW-1:0];
      sum_wdata = '0;
      sum_re    = 1'b0;
      sum_raddr = c_ff[CW-1:0];
      div_start = 1'b0;

      s1_vld_in = s1_adv ? 1'b0 : s1_vld_ff;
      s1_op_in  = s1_op_ff;
      s1_inr_in = s1_inr_ff;

      // host requests, taken only in idle
      if (accept) begin
         case (req_operation)
            km2d_pkg::OP_WR_CEN: cen_we = 32'(req_index) < MAX_CLASSES;
            km2d_pkg::OP_WR_PT:  pt_we  = 32'(req_index) < MAX_POINTS;
            km2d_pkg::OP_RD_CEN: cen_re = 32'(req_index) < MAX_CLASSES;
            km2d_pkg::OP_RD_LBL: lbl_re = 32'(req_index) < MAX_POINTS;
            default: ;
         endcase
         if (req_operation == km2d_pkg::OP_RUN) begin
            state_in = ST_START;
         end else begin
            s1_vld_in = 1'b1;
            s1_op_in  = req_operation;
            s1_inr_in = (req_operation == km2d_pkg::OP_RD_CEN) ?
                        (32'(req_index) < MAX_CLASSES) : (32'(req_index) < MAX_POINTS);
         end
      end

      case (state_ff)
         ST_CLR: begin
            lbl_we    = 1'b1;
            lbl_waddr = p_ff[PW-1:0];
            lbl_wdata = '0;
            p_in      = p_ff + 1'b1;
            if ((p_ff + 1'b1) == PCW'(MAX_POINTS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: ;
         ST_START: begin
            c_in  = '0;
            p_in  = '0;
            it_in = iter_ff;
            state_in = (iter_ff == '0 || n_eff == '0) ? ST_FIN : ST_SCLR;
         end
         ST_SCLR: begin
            sum_we = 1'b1;
            c_in   = c_ff + 1'b1;
            if (last_c) begin
               p_in     = '0;
               state_in = ST_PRD;
            end
         end
         ST_PRD: begin
            pt_re    = 1'b1;
            c_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cen_re       = 1'b1;
            cen_raddr    = c_ff[CW-1:0];
            tag_vld_in   = 1'b1;
            tag_first_in = (c_ff == '0);
            tag_cls_in   = c_ff[CW-1:0];
            c_in         = c_ff + 1'b1;
            if (last_c) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!tag_vld_ff && !dist_busy) begin
               state_in = ST_ARD;
            end
         end
         ST_ARD: begin
            sum_re    = 1'b1;
            sum_raddr = best;
            state_in  = ST_AWR;
         end
         ST_AWR: begin
            sum_we    = 1'b1;
            sum_waddr = best;
            sum_wdata = {acc_x, acc_y, acc_n};
            lbl_we    = 1'b1;
            p_in      = p_ff + 1'b1;
            if (last_p) begin
               c_in     = '0;
               state_in = ST_URD;
            end else begin
               state_in = ST_PRD;
            end
         end
         ST_URD: begin
            sum_re   = 1'b1;
            state_in = ST_UCHK;
         end
         ST_UCHK, ST_UWR: begin
            if (state_ff == ST_UCHK && sum_n != '0) begin
               div_start = 1'b1;
               sgn_x_in  = sum_x[SW-1];
               sgn_y_in  = sum_y[SW-1];
               state_in  = ST_UDIV;
            end else begin
               // empty class keeps its centroid
               if (state_ff == ST_UWR) begin
                  cen_we    = 1'b1;
                  cen_waddr = c_ff[CW-1:0];
                  cen_wdata = {q_x, q_y};
               end
               if (last_c) begin
                  c_in = '0;
                  if (it_ff == km2d_pkg::ITER_W'(1)) begin
                     state_in = ST_FIN;
                  end else begin
                     it_in    = it_ff - 1'b1;
                     state_in = ST_SCLR;
                  end
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = ST_URD;
               end
            end
         end
         ST_UDIV: begin
            if (!div_busy_x && !div_busy_y) begin
               state_in = ST_UWR;
            end
         end
         ST_FIN: begin
            if (!s1_vld_ff || s1_adv) begin
               s1_vld_in = 1'b1;
               s1_op_in  = km2d_pkg::OP_RUN;
               s1_inr_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_lbl_in  = rsp_lbl_ff;
      rsp_done_in = rsp_done_ff;
      if (s1_vld_ff && s1_adv) begin
         rsp_vld_in  = 1'b1;
         rsp_x_in    = '0;
         rsp_y_in    = '0;
         rsp_lbl_in  = '0;
         rsp_done_in = 1'b1;
         case (s1_op_ff)
            km2d_pkg::OP_WR_CEN, km2d_pkg::OP_WR_PT, km2d_pkg::OP_RUN: ;
            km2d_pkg::OP_RD_CEN: begin
               if (s1_inr_ff) begin
                  rsp_x_in = km2d_pkg::FIELD_W'(cen_x);
                  rsp_y_in = km2d_pkg::FIELD_W'(cen_y);
               end
            end
            km2d_pkg::OP_RD_LBL: begin
               if (s1_inr_ff) begin
                  rsp_lbl_in = km2d_pkg::LABEL_W'(lbl_rdata);
               end
            end
            default: rsp_done_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         p_ff       <= '0;
         c_ff       <= '0;
         it_ff      <= '0;
         tag_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_ff       <= p_in;
         c_ff       <= c_in;
         it_ff      <= it_in;
         tag_vld_ff <= tag_vld_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      tag_first_ff <= tag_first_in;
      tag_cls_ff   <= tag_cls_in;
      sgn_x_ff     <= sgn_x_in;
      sgn_y_ff     <= sgn_y_in;
      s1_op_ff     <= s1_op_in;
      s1_inr_ff    <= s1_inr_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_lbl_ff   <= rsp_lbl_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_read_x     = rsp_x_ff;
   assign rsp_read_y     = rsp_y_ff;
   assign rsp_read_label = rsp_lbl_ff;
   assign rsp_done_res   = rsp_done_ff;

   // ---------------- assertions ----------------
   `KM2D_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE,
                    "request taken outside idle")
   `KM2D_ASSERT_NXT(a_s1_hold, clock, reset, s1_vld_ff && !s1_adv, s1_vld_ff,
                    "front stage dropped a stalled request")
   `KM2D_ASSERT_IMP(a_div_free, clock, reset, div_start, !div_busy_x && !div_busy_y,
                    "divider started while busy")
   `KM2D_ASSERT_IMP(a_lbl_range, clock, reset, lbl_we && state_ff == ST_AWR, p_ff < n_eff,
                    "label write beyond point count")

endmodule

FILE: verif/km2d_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and csr channels, keeps its own copy of the
// clustering state and compares every response with the predicted one.
module km2d_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [km2d_pkg::OP_W-1:0]           req_operation,
   input  logic [km2d_pkg::IDX_W-1:0]          req_index,
   input  logic signed [km2d_pkg::FIELD_W-1:0] req_coord_x,
   input  logic signed [km2d_pkg::FIELD_W-1:0] req_coord_y,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [km2d_pkg::FIELD_W-1:0] rsp_read_x,
   input  logic signed [km2d_pkg::FIELD_W-1:0] rsp_read_y,
   input  logic [km2d_pkg::LABEL_W-1:0]        rsp_read_label,
   input  logic                                rsp_done_res,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [km2d_pkg::CSR_W-1:0]          csr_index,
   input  logic [km2d_pkg::FIELD_W-1:0]        csr_data,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int NPT = km2d_pkg::DEF_MAX_POINTS;
   localparam int NCL = km2d_pkg::DEF_MAX_CLASSES;
   localparam int FW  = km2d_pkg::FIELD_W;
   localparam int LW  = km2d_pkg::LABEL_W;

   typedef struct {
      logic signed [FW-1:0] x;
      logic signed [FW-1:0] y;
      logic [LW-1:0]        lbl;
      logic                 done;
   } km_result_type;

   km_result_type expected_q[$];

   logic signed [FW-1:0] pt_x [NPT];
   logic signed [FW-1:0] pt_y [NPT];
   logic signed [FW-1:0] cen_x [NCL];
   logic signed [FW-1:0] cen_y [NCL];
   logic [LW-1:0]        label_mem [NPT];
   int unsigned iter_reg, class_reg, point_reg;

   // assign all points, then move centroids to member means; empty class keeps its spot
   function automatic void lloyd_rounds();
      int k, n, best;
      longint d, best_d, dx, dy;
      longint sx [NCL];
      longint sy [NCL];
      longint cnt [NCL];
      k = class_reg;
      n = point_reg;
      if (k < 1) k = 1;
      if (k > NCL) k = NCL;
      if (n > NPT) n = NPT;
      for (int it = 0; it < iter_reg; it++) begin
         for (int p = 0; p < n; p++) begin
            best = 0;
            best_d = 0;
            for (int c = 0; c < k; c++) begin
               dx = longint'(pt_x[p]) - longint'(cen_x[c]);
               dy = longint'(pt_y[p]) - longint'(cen_y[c]);
               d = dx * dx + dy * dy;
               if (c == 0 || d < best_d) begin
                  best = c;
                  best_d = d;
               end
            end
            label_mem[p] = best[LW-1:0];
         end
         for (int c = 0; c < NCL; c++) begin
            sx[c] = 0;
            sy[c] = 0;
            cnt[c] = 0;
         end
         for (int p = 0; p < n; p++) begin
            sx[label_mem[p]] += longint'(pt_x[p]);
            sy[label_mem[p]] += longint'(pt_y[p]);
            cnt[label_mem[p]]++;
         end
         for (int c = 0; c < k; c++) begin
            if (cnt[c] != 0) begin
               // signed divide truncates toward zero
               cen_x[c] = FW'(sx[c] / cnt[c]);
               cen_y[c] = FW'(sy[c] / cnt[c]);
            end
         end
      end
   endfunction

   function automatic km_result_type predict_request(logic [km2d_pkg::OP_W-1:0] op,
                                                     logic [km2d_pkg::IDX_W-1:0] idx,
                                                     logic signed [FW-1:0] x,
                                                     logic signed [FW-1:0] y);
      km_result_type r;
      r.x = '0;
      r.y = '0;
      r.lbl = '0;
      r.done = 1'b1;
      case (op)
         km2d_pkg::OP_WR_CEN: begin
            if (idx < NCL) begin
               cen_x[idx] = x;
               cen_y[idx] = y;
            end
         end
         km2d_pkg::OP_WR_PT: begin
            pt_x[idx] = x;
            pt_y[idx] = y;
         end
         km2d_pkg::OP_RUN: lloyd_rounds();
         km2d_pkg::OP_RD_CEN: begin
            if (idx < NCL) begin
               r.x = cen_x[idx];
               r.y = cen_y[idx];
            end
         end
         km2d_pkg::OP_RD_LBL: r.lbl = label_mem[idx];
         default: r.done = 1'b0;
      endcase
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      km_result_type e;
      if (reset) begin
         expected_q.delete();
         iter_reg = 1;
         class_reg = 16;
         point_reg = 1024;
         foreach (label_mem[i]) label_mem[i] = '0;
      end else begin
         // response first so a stray one cannot match a request of this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response x=%0d y=%0d label=%0d done=%0d", $time,
                        rsp_read_x, rsp_read_y, rsp_read_label, rsp_done_res);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_read_x !== e.x || rsp_read_y !== e.y ||
                   rsp_read_label !== e.lbl || rsp_done_res !== e.done) begin
                  $display("%0t: mismatch expected x=%0d y=%0d label=%0d done=%0d", $time,
                           e.x, e.y, e.lbl, e.done);
                  $display("%0t:          actual   x=%0d y=%0d label=%0d done=%0d", $time,
                           rsp_read_x, rsp_read_y, rsp_read_label, rsp_done_res);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               km2d_pkg::CSR_ITER:  iter_reg = csr_data;
               km2d_pkg::CSR_CLASS: class_reg = csr_data[km2d_pkg::KREG_W-1:0];
               km2d_pkg::CSR_POINT: point_reg = csr_data[km2d_pkg::NREG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_request(req_operation, req_index,
                                                 req_coord_x, req_coord_y));
      end
      pending = expected_q.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the k-means block; all checking lives in km2d_checker.
module testbench;

   localparam int NPT       = km2d_pkg::DEF_MAX_POINTS;
   localparam int NCL       = km2d_pkg::DEF_MAX_CLASSES;
   localparam int OPW       = km2d_pkg::OP_W;
   localparam int IXW       = km2d_pkg::IDX_W;
   localparam int FW        = km2d_pkg::FIELD_W;
   localparam int CYC_LIMIT = 4000000;   // worst case run plus stalls, with margin
   localparam int PHASES    = 6;
   localparam int PHASE_REQ = 120;
   localparam int FILL_PTS  = 256;       // points loaded for the closing runs

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OPW-1:0] req_operation = km2d_pkg::OP_WR_CEN;
   logic [IXW-1:0] req_index = '0;
   logic signed [FW-1:0] req_coord_x = '0;
   logic signed [FW-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [FW-1:0] rsp_read_x, rsp_read_y;
   logic [km2d_pkg::LABEL_W-1:0] rsp_read_label;
   logic rsp_done_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [km2d_pkg::CSR_W-1:0] csr_index = km2d_pkg::CSR_ITER;
   logic [FW-1:0] csr_data = '0;

   int fail_count, pending;
   int unsigned cyc = 0;
   int run_count = 0, req_count = 0;

   // bookkeeping so no run or read touches a store entry never written
   bit pt_written [NPT];
   bit cen_written [NCL];
   int cur_k, cur_n;           // class and point count in effect (saturated)
   bit runs_allowed;

   // stall control: long receiver hold-off and quiet windows with no idling
   bit hold_go = 1'b0;
   int hold_left = 0;
   wire quiet = (cyc % 5000) < 800;

   always #5 clock = ~clock;

   kmeans_2d_clustering u_top (.*);

   km2d_checker u_checker (.*);

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cyc);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random back-pressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (hold_go) begin
         hold_go = 1'b0;
         hold_left = 400;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = quiet || ($urandom_range(99) >= 10);
      end
   end

   task automatic send_req(logic [OPW-1:0] op, logic [IXW-1:0] idx,
                           logic [FW-1:0] x, logic [FW-1:0] y);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 10) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_index = idx;
      req_coord_x = x;
      req_coord_y = y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
      if (op == km2d_pkg::OP_WR_PT) pt_written[idx] = 1'b1;
      if (op == km2d_pkg::OP_WR_CEN && idx < NCL) cen_written[idx] = 1'b1;
      if (op == km2d_pkg::OP_RUN) run_count++;
   endtask

   task automatic send_csr(logic [km2d_pkg::CSR_W-1:0] idx, logic [FW-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < 10) begin
         csr_valid = 1'b0;
         @(negedge clock);
      end
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // junk in the unused upper bits: the block keeps only the low field
   task automatic set_config(int iters, int classes, int points);
      send_csr(km2d_pkg::CSR_ITER, iters[15:0]);
      send_csr(km2d_pkg::CSR_CLASS, {11'($urandom), classes[4:0]});
      send_csr(km2d_pkg::CSR_POINT, {5'($urandom), points[10:0]});
      cur_k = (classes[4:0] == 0) ? 1 : (classes[4:0] > NCL) ? NCL : classes[4:0];
      cur_n = (points[10:0] > NPT) ? NPT : points[10:0];
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // a run needs every centroid and point it will touch; otherwise load the first gap
   task automatic send_run();
      for (int c = 0; c < cur_k; c++)
         if (!cen_written[c]) begin
            send_req(km2d_pkg::OP_WR_CEN, c, $urandom, $urandom);
            return;
         end
      for (int p = 0; p < cur_n; p++)
         if (!pt_written[p]) begin
            send_req(km2d_pkg::OP_WR_PT, p, $urandom, $urandom);
            return;
         end
      send_req(km2d_pkg::OP_RUN, $urandom, $urandom, $urandom);
   endtask

   task automatic random_req();
      int r, idx;
      r = $urandom_range(99);
      if (r < 30) begin
         idx = ($urandom_range(9) == 0) ? $urandom_range(NPT - 1) : $urandom_range(127);
         send_req(km2d_pkg::OP_WR_PT, idx, $urandom, $urandom);
      end else if (r < 42) begin
         send_req(km2d_pkg::OP_WR_CEN, ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                                 : $urandom_range(19),
                  $urandom, $urandom);
      end else if (r < 52) begin
         if (runs_allowed) send_run();
         else send_req(km2d_pkg::OP_RD_LBL, $urandom, $urandom, $urandom);
      end else if (r < 70) begin
         idx = $urandom_range(1023);
         if ($urandom_range(1)) idx = idx % 20;
         if (idx < NCL && !cen_written[idx]) idx = idx + NCL;
         send_req(km2d_pkg::OP_RD_CEN, idx, $urandom, $urandom);
      end else if (r < 94) begin
         send_req(km2d_pkg::OP_RD_LBL,
                  $urandom_range(1) ? $urandom_range(127) : $urandom_range(1023),
                  $urandom, $urandom);
      end else begin
         send_req($urandom_range(7, 5), $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int iters, classes, points;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, tie between identical centroids, empty class
      set_config(1, 4, 8);
      send_req(km2d_pkg::OP_WR_CEN, 0, 16'h8000, 16'h8000);
      send_req(km2d_pkg::OP_WR_CEN, 1, 16'h7FFF, 16'h7FFF);
      send_req(km2d_pkg::OP_WR_CEN, 2, 16'h0000, 16'h0000);
      send_req(km2d_pkg::OP_WR_CEN, 3, 16'h0000, 16'h0000);   // same as class 2: never wins
      send_req(km2d_pkg::OP_WR_PT, 0, 16'h8000, 16'h8000);
      send_req(km2d_pkg::OP_WR_PT, 1, 16'h7FFF, 16'h7FFF);
      send_req(km2d_pkg::OP_WR_PT, 2, 16'h0000, 16'h0000);
      send_req(km2d_pkg::OP_WR_PT, 3, 16'h0100, 16'hFF00);
      send_req(km2d_pkg::OP_WR_PT, 4, 16'hFFFF, 16'h0001);
      send_req(km2d_pkg::OP_WR_PT, 5, 16'h5555, 16'hAAAA);
      send_req(km2d_pkg::OP_WR_PT, 6, 16'h0064, 16'h0064);
      send_req(km2d_pkg::OP_WR_PT, 7, 16'hFF9C, 16'hFF9C);
      send_req(km2d_pkg::OP_WR_CEN, 1023, 16'h1234, 16'h4321);  // out of range: dropped
      send_req(km2d_pkg::OP_RD_LBL, 5, 0, 0);                   // labels start at zero
      send_req(km2d_pkg::OP_RUN, 0, 0, 0);
      for (int c = 0; c < 4; c++) send_req(km2d_pkg::OP_RD_CEN, c, 0, 0);
      send_req(km2d_pkg::OP_RD_LBL, 0, 0, 0);
      send_req(km2d_pkg::OP_RD_LBL, 1, 0, 0);
      send_req(km2d_pkg::OP_RD_LBL, 2, 0, 0);
      send_req(km2d_pkg::OP_RD_LBL, 4, 0, 0);
      send_req(km2d_pkg::OP_RD_LBL, 1023, 0, 0);
      send_req(3'd5, 10'h3FF, 16'hFFFF, 16'hFFFF);
      send_req(3'd6, 0, 0, 0);
      send_req(3'd7, 10'h2AA, 16'h1234, 16'h5678);
      send_req(km2d_pkg::OP_RD_CEN, 1023, 0, 0);
      wait_drain();

      // random phases, each with its own setting
      for (int ph = 0; ph < PHASES; ph++) begin
         iters = (ph == 2) ? 0 : (ph == 4) ? 65535 : $urandom_range(1, 4);
         classes = (ph == 1) ? 0 : (ph == 3) ? 31 : $urandom_range(1, 16);
         points = (ph == 3) ? 0 : (ph == 5) ? 1 : $urandom_range(2, 64);
         // 65535 rounds would take far too long: that setting sees loads, reads and unknown ops, no run
         runs_allowed = (ph != 4);
         set_config(iters, classes, points);
         if (ph == 0) hold_go = 1'b1;   // long receiver stall while requests keep coming
         for (int i = 0; i < PHASE_REQ; i++) random_req();
         wait_drain();
      end

      // larger point set with every class in use, one and two rounds
      for (int p = 0; p < FILL_PTS; p++)
         if (!pt_written[p]) send_req(km2d_pkg::OP_WR_PT, p, $urandom, $urandom);
      for (int c = 0; c < NCL; c++)
         if (!cen_written[c]) send_req(km2d_pkg::OP_WR_CEN, c, $urandom, $urandom);
      wait_drain();
      set_config(1, 16, FILL_PTS);
      send_run();
      for (int c = 0; c < NCL; c++) send_req(km2d_pkg::OP_RD_CEN, c, 0, 0);
      repeat (12) send_req(km2d_pkg::OP_RD_LBL, $urandom, 0, 0);
      wait_drain();
      set_config(2, 16, FILL_PTS);
      send_run();
      repeat (8) send_req(km2d_pkg::OP_RD_LBL, $urandom, 0, 0);
      send_req(km2d_pkg::OP_RD_CEN, $urandom_range(15), 0, 0);
      wait_drain();

      $display("covered %0d requests incl. %0d runs over class/point/round settings",
               req_count, run_count);
      $display("with extremes, tie and empty class, out-of-range indexes, unknown ops");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
